/* sv/flc_pkg.sv */
// Package for the fan level controller: word types, register indexes,
// policy codes, built-in trip points and the duty table. No dependencies.
package flc_pkg;

    // PWM range in ticks; the duty table below follows from it.
    localparam int unsigned PWM_RANGE = 2078;

    // Input word: one poll tick.
    typedef struct packed {
        logic [9:0] sensor_code;
        logic       sensor_ok;
    } t_in_word;

    // Result word: one per tick.
    typedef struct packed {
        logic [2:0]         cool_level;
        logic [11:0]        duty_ticks;
        logic               level_changed;
        logic signed [19:0] temp_milli;
        logic               temp_ok;
    } t_out_word;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [2:0] REG_POLICY_MODE       = 3'd0;
    localparam logic [2:0] REG_FIXED_LEVEL       = 3'd1;
    localparam logic [2:0] REG_CUSTOM_TRIP_ONE   = 3'd2;
    localparam logic [2:0] REG_CUSTOM_TRIP_TWO   = 3'd3;
    localparam logic [2:0] REG_CUSTOM_TRIP_THREE = 3'd4;
    localparam logic [2:0] REG_CUSTOM_TRIP_FOUR  = 3'd5;
    localparam logic [2:0] REG_OVERRIDE_ENABLE   = 3'd6;
    localparam logic [2:0] REG_OVERRIDE_LEVEL    = 3'd7;

    // Policy modes; the remaining code behaves as auto.
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_FIXED  = 2'd1;
    localparam logic [1:0] MODE_CUSTOM = 2'd2;

    // Level limits.
    localparam logic [2:0] LEVEL_MAX  = 3'd4;
    localparam logic [2:0] LEVEL_SAFE = 3'd2;

    // Custom trip sanity limits in whole degrees.
    localparam logic [7:0] TRIP_LOW_C  = 8'd30;
    localparam logic [7:0] TRIP_HIGH_C = 8'd90;

    // Temperature decode and hysteresis, in milli-degrees.
    localparam logic signed [20:0] TEMP_OFFSET = 21'sd450000;
    localparam logic [19:0]        TEMP_SCALE  = 20'd550;
    localparam logic signed [20:0] HYST_MILLI  = 21'sd5000;
    localparam logic [17:0]        MILLI_PER_C = 18'd1000;

    // Built-in trip points, in milli-degrees.
    localparam logic signed [20:0] TRIP_ONE   = 21'sd50000;
    localparam logic signed [20:0] TRIP_TWO   = 21'sd60000;
    localparam logic signed [20:0] TRIP_THREE = 21'sd67500;
    localparam logic signed [20:0] TRIP_FOUR  = 21'sd75000;

    // Rounded duty in ticks for each level, from the duty/255 table.
    localparam int unsigned DUTY_ONE   = (75 * PWM_RANGE + 127) / 255;
    localparam int unsigned DUTY_TWO   = (125 * PWM_RANGE + 127) / 255;
    localparam int unsigned DUTY_THREE = (175 * PWM_RANGE + 127) / 255;
    localparam int unsigned DUTY_FOUR  = (250 * PWM_RANGE + 127) / 255;

    // Duty lookup; levels above four read as level four.
    function automatic logic [11:0] duty_for_level(input logic [2:0] level);
        logic [11:0] duty;
        case (level)
            3'd0:    duty = 12'd0;
            3'd1:    duty = 12'(DUTY_ONE);
            3'd2:    duty = 12'(DUTY_TWO);
            3'd3:    duty = 12'(DUTY_THREE);
            default: duty = 12'(DUTY_FOUR);
        endcase
        return duty;
    endfunction

endpackage

/* sv/fan_level_controller_hysteresis.sv */
// Fan level controller with hysteresis: top level with register file and datapath.
// Depends on flc_pkg for word types, register indexes and constants.
//
// The block takes one temperature word per poll tick and returns one result word
// per tick: the commanded fan level 0..4, its PWM duty in ticks, a level-changed
// flag, the decoded temperature in milli-degrees and the sensor validity. It
// accepts one word every clock cycle while results are taken; an accepted word
// lands in the input register and moves into the result register when that
// register is empty or its result is taken, and the level decision with its
// feedback of the held level sits between them. A stalled result holds the input
// register, so input stalls only follow output stalls. With a valid sensor and no
// override or fixed level, levels rise at once and fall by one per tick once the
// temperature is more than five degrees below the held level's trip. Configuration
// goes through the APB port, register i at byte address 4*i; the user must see
// that it is written only while the block is idle; the block does not enforce it.

module fan_level_controller_hysteresis (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input word channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  flc_pkg::t_in_word  i_in_data,
    // Result word channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output flc_pkg::t_out_word o_out_data,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import flc_pkg::*;

    // Configuration registers.
    logic [1:0] r_policy_mode;
    logic [2:0] r_fixed_level;
    logic [7:0] r_trip_one;
    logic [7:0] r_trip_two;
    logic [7:0] r_trip_three;
    logic [7:0] r_trip_four;
    logic       r_override_enable;
    logic [2:0] r_override_level;

    // Pipeline and state registers.
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic [2:0] r_cur_level;
    logic       r_known;

    logic       w_cfg_write;
    logic [2:0] w_reg_index;
    logic       w_advance;
    logic       w_take;

    // Configuration write strobe and register index.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite;
    assign w_reg_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_mode     <= MODE_AUTO;
            r_fixed_level     <= 3'd2;
            r_trip_one        <= 8'd50;
            r_trip_two        <= 8'd60;
            r_trip_three      <= 8'd68;
            r_trip_four       <= 8'd75;
            r_override_enable <= 1'b0;
            r_override_level  <= 3'd0;
        end else if (w_cfg_write) begin
            case (w_reg_index)
                REG_POLICY_MODE:       r_policy_mode     <= pwdata[1:0];
                REG_FIXED_LEVEL:       r_fixed_level     <= pwdata[2:0];
                REG_CUSTOM_TRIP_ONE:   r_trip_one        <= pwdata[7:0];
                REG_CUSTOM_TRIP_TWO:   r_trip_two        <= pwdata[7:0];
                REG_CUSTOM_TRIP_THREE: r_trip_three      <= pwdata[7:0];
                REG_CUSTOM_TRIP_FOUR:  r_trip_four       <= pwdata[7:0];
                REG_OVERRIDE_ENABLE:   r_override_enable <= pwdata[0];
                REG_OVERRIDE_LEVEL:    r_override_level  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (w_reg_index)
            REG_POLICY_MODE:       prdata = {30'd0, r_policy_mode};
            REG_FIXED_LEVEL:       prdata = {29'd0, r_fixed_level};
            REG_CUSTOM_TRIP_ONE:   prdata = {24'd0, r_trip_one};
            REG_CUSTOM_TRIP_TWO:   prdata = {24'd0, r_trip_two};
            REG_CUSTOM_TRIP_THREE: prdata = {24'd0, r_trip_three};
            REG_CUSTOM_TRIP_FOUR:  prdata = {24'd0, r_trip_four};
            REG_OVERRIDE_ENABLE:   prdata = {31'd0, r_override_enable};
            REG_OVERRIDE_LEVEL:    prdata = {29'd0, r_override_level};
            default:               prdata = 32'd0;
        endcase
    end

    // Handshake: the result register moves when empty or taken, the input
    // register when empty or when its word moves on.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_take     = r_in_valid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Temperature decode.
    logic [19:0]        w_prod;
    logic signed [20:0] w_milli;

    assign w_prod  = 20'(r_in.sensor_code) * TEMP_SCALE;
    assign w_milli = r_in.sensor_ok ? (TEMP_OFFSET - $signed({1'b0, w_prod})) : 21'sd0;

    // Custom trips are used only when the mode asks for them and they are sane.
    logic w_custom;

    assign w_custom = (r_policy_mode == MODE_CUSTOM)
                   && (r_trip_one >= TRIP_LOW_C) && (r_trip_four <= TRIP_HIGH_C)
                   && (r_trip_one < r_trip_two) && (r_trip_two < r_trip_three)
                   && (r_trip_three < r_trip_four);

    // Trip points in milli-degrees.
    logic [17:0]        w_c1, w_c2, w_c3, w_c4;
    logic signed [20:0] w_t1, w_t2, w_t3, w_t4;

    assign w_c1 = 18'(r_trip_one) * MILLI_PER_C;
    assign w_c2 = 18'(r_trip_two) * MILLI_PER_C;
    assign w_c3 = 18'(r_trip_three) * MILLI_PER_C;
    assign w_c4 = 18'(r_trip_four) * MILLI_PER_C;

    assign w_t1 = w_custom ? $signed({3'd0, w_c1}) : TRIP_ONE;
    assign w_t2 = w_custom ? $signed({3'd0, w_c2}) : TRIP_TWO;
    assign w_t3 = w_custom ? $signed({3'd0, w_c3}) : TRIP_THREE;
    assign w_t4 = w_custom ? $signed({3'd0, w_c4}) : TRIP_FOUR;

    // Trip of the held level, for the hysteresis test.
    logic signed [20:0] w_hold_trip;

    always_comb begin
        case (r_cur_level)
            3'd1:    w_hold_trip = w_t1;
            3'd2:    w_hold_trip = w_t2;
            3'd3:    w_hold_trip = w_t3;
            default: w_hold_trip = w_t4;
        endcase
    end

    // Level choice: override, fixed, invalid sensor floor, then the trip curve.
    logic [2:0] w_curve;
    logic [2:0] n_level;
    logic       n_changed;

    always_comb begin
        if (w_milli >= w_t4) begin
            w_curve = 3'd4;
        end else if (w_milli >= w_t3) begin
            w_curve = 3'd3;
        end else if (w_milli >= w_t2) begin
            w_curve = 3'd2;
        end else if (w_milli >= w_t1) begin
            w_curve = 3'd1;
        end else begin
            w_curve = 3'd0;
        end

        n_level = r_cur_level;
        if (r_override_enable) begin
            n_level = (r_override_level > LEVEL_MAX) ? LEVEL_MAX : r_override_level;
        end else if (r_policy_mode == MODE_FIXED) begin
            n_level = (r_fixed_level > LEVEL_MAX) ? LEVEL_SAFE : r_fixed_level;
        end else if (!r_in.sensor_ok) begin
            if (!r_known || r_cur_level < LEVEL_SAFE) begin
                n_level = LEVEL_SAFE;
            end
        end else if (r_known && w_curve < r_cur_level) begin
            // Fall one step only once the temperature is well below the held trip.
            if (w_milli >= w_hold_trip - HYST_MILLI) begin
                n_level = r_cur_level;
            end else begin
                n_level = r_cur_level - 3'd1;
            end
        end else begin
            n_level = w_curve;
        end

        n_changed = !r_known || (n_level != r_cur_level);
    end

    // Held level and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_level <= 3'd0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
            if (w_take) begin
                r_cur_level <= n_level;
                r_known     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out.cool_level    <= n_level;
            r_out.duty_ticks    <= duty_for_level(n_level);
            r_out.level_changed <= n_changed;
            r_out.temp_milli    <= w_milli[19:0];
            r_out.temp_ok       <= r_in.sensor_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The held level never leaves the legal range.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_level <= LEVEL_MAX)
        else $error("held fan level out of range");

    // A waiting result implies a level has been commanded.
    a_known_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_known)
        else $error("result pending with no level known");

    // The shown result always reports the held level.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.cool_level == r_cur_level))
        else $error("result level differs from held level");

    // A stalled result freezes the held level.
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_cur_level))
        else $error("held level moved during output stall");

endmodule
